// ===== rtl/kss_pkg.sv =====
`default_nettype none

package kss_pkg;

  // Store geometry.
  localparam int CAPACITY   = 64;
  localparam int VALUE_BITS = 32;

  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int LEAVES   = 1 << IDX_W;
  localparam int ACC_W    = VALUE_BITS + IDX_W;
  localparam int TREE_LAT = (IDX_W + 1) / 2;
  localparam int LAT_W    = $clog2(TREE_LAT) + 1;

  // Fixed field widths of the item payloads.
  localparam int OP_W     = 3;
  localparam int IN_VAL_W = 32;
  localparam int K_W      = 7;
  localparam int SUM_W    = 38;
  localparam int OCNT_W   = 7;
  localparam int STAT_W   = 2;
  localparam int CMP_W    = (CNT_W > K_W) ? CNT_W : K_W;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
  localparam logic [OP_W-1:0] OP_ERASE  = 3'd1;
  localparam logic [OP_W-1:0] OP_SMALL  = 3'd2;
  localparam logic [OP_W-1:0] OP_LARGE  = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

  // Status codes.
  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;

  typedef logic signed [VALUE_BITS-1:0] val_t;
  typedef logic signed [ACC_W-1:0]      acc_t;
  typedef logic [CNT_W-1:0]             cnt_t;
  typedef logic [IDX_W-1:0]             idx_t;

  typedef struct packed {
    logic [OP_W-1:0]            op;
    logic signed [IN_VAL_W-1:0] value;
    logic [K_W-1:0]             k;
  } kss_in_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] sum;
    logic [OCNT_W-1:0]       count;
    logic [STAT_W-1:0]       status;
  } kss_out_t;

  // Control broadcast from the sequencer to every cell.
  typedef struct packed {
    logic cmp;
    logic ins_en;
    logic era_en;
    logic sum_small;
    logic sum_large;
    val_t val;
    cnt_t n;
    cnt_t kc;
  } kss_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/kss_cell.sv =====
`default_nettype none

module kss_cell (
  input  logic             clk,
  input  kss_pkg::idx_t    idx,
  input  kss_pkg::kss_ctl_t ctl,
  input  kss_pkg::val_t    left_value,
  input  logic             left_le,
  input  kss_pkg::val_t    right_value,
  output kss_pkg::val_t    value,
  output logic             le,
  output logic             eq,
  output kss_pkg::val_t    leaf
);
  import kss_pkg::*;

  val_t value_r;
  logic le_r;
  logic eq_r;
  logic incl_r;
  logic valid;
  logic lt;
  cnt_t pos;

  assign pos   = CNT_W'(idx);
  assign valid = pos < ctl.n;
  // Flags are gated by valid, so cells above the count never match.
  assign lt    = le_r && !eq_r;

  always_ff @(posedge clk) begin
    if (ctl.cmp) begin
      le_r   <= valid && (value_r <= ctl.val);
      eq_r   <= valid && (value_r == ctl.val);
      incl_r <= (ctl.sum_small && (pos < ctl.kc)) ||
                (ctl.sum_large && valid && (pos >= (ctl.n - ctl.kc)));
    end
    if (ctl.ins_en) begin
      // Cells holding larger values move up; the first of them takes the new value.
      if (!le_r) begin
        value_r <= left_le ? ctl.val : left_value;
      end
    end else if (ctl.era_en) begin
      if (!lt) begin
        value_r <= right_value;
      end
    end
  end

  assign value = value_r;
  assign le    = le_r;
  assign eq    = eq_r;
  assign leaf  = incl_r ? value_r : '0;

endmodule

`default_nettype wire

// ===== rtl/kss_sum_tree.sv =====
`default_nettype none

module kss_sum_tree (
  input  logic          clk,
  input  kss_pkg::val_t leaf [kss_pkg::CAPACITY],
  output kss_pkg::acc_t sum
);
  import kss_pkg::*;

  acc_t node   [0:IDX_W][0:LEAVES-1];
  acc_t node_r [0:IDX_W][0:LEAVES-1];

  // A register follows every second level and the root.
  always_comb begin
    for (int l = 0; l <= IDX_W; l++) begin
      for (int j = 0; j < LEAVES; j++) begin
        node[l][j] = '0;
      end
    end
    for (int j = 0; j < CAPACITY; j++) begin
      node[0][j] = ACC_W'(leaf[j]);
    end
    for (int l = 1; l <= IDX_W; l++) begin
      for (int j = 0; j < (LEAVES >> l); j++) begin
        if ((l % 2 == 0) || (l == IDX_W)) begin
          node[l][j] = node_r[l][j];
        end else begin
          node[l][j] = node[l-1][2*j] + node[l-1][2*j+1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l <= IDX_W; l++) begin
      for (int j = 0; j < LEAVES; j++) begin
        if ((l >= 1) && (j < (LEAVES >> l))) begin
          node_r[l][j] <= node[l-1][2*j] + node[l-1][2*j+1];
        end else begin
          node_r[l][j] <= '0;
        end
      end
    end
  end

  assign sum = node[IDX_W][0];

endmodule

`default_nettype wire

// ===== rtl/k_smallest_sum_multiset_top.sv =====
`default_nettype none

// Channel   Direction  Handshake             Payload
// in_       input      in_valid / in_ready   in_data   (op, value, k)
// out_      output     out_valid / out_ready out_data  (sum, count, status)
//
// An item is taken only while the sequencer is idle. Insert, erase, clear and
// unknown codes pass a compare step and then an apply step that writes the
// result; sums go on from the apply step to a sum step that waits on the
// registered adder tree, set by its depth. The next item can be taken only once
// the result is written and the sequencer is idle again, never before.
// Reset is synchronous and active low; it clears the entry count and the handshakes.
// A stalled output holds the finished item while the block waits in its last step.

module k_smallest_sum_multiset_top (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  kss_pkg::kss_in_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output kss_pkg::kss_out_t out_data
);
  import kss_pkg::*;

  // Sequencer states.
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CMP  = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;
  localparam logic [1:0] S_SUM  = 2'd3;

  logic [1:0]      state_r, state_nxt;
  cnt_t            count_r, count_nxt;
  logic [LAT_W-1:0] lat_r, lat_nxt;
  logic            out_valid_r, out_valid_nxt;
  kss_out_t        out_data_r, out_data_nxt;

  // Item fields held for the duration of the operation.
  logic [OP_W-1:0] op_r;
  val_t            val_r;
  cnt_t            kc_r;

  logic            out_free;
  logic            found;
  logic            ins_en;
  logic            era_en;
  logic            full;
  logic [CMP_W-1:0] k_ext;
  logic [CMP_W-1:0] cnt_ext;
  kss_ctl_t        ctl;
  acc_t            tree_sum;

  val_t            cell_val  [CAPACITY];
  val_t            cell_leaf [CAPACITY];
  logic [CAPACITY-1:0] cell_le;
  logic [CAPACITY-1:0] cell_eq;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || out_ready;
  // Equal values sit next to each other, so any match means the value is held.
  assign found     = |cell_eq;
  assign full      = (count_r == CNT_W'(CAPACITY));
  assign k_ext     = CMP_W'(in_data.k);
  assign cnt_ext   = CMP_W'(count_r);

  // The k field is clamped to the count when the item is taken.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_r  <= in_data.op;
      val_r <= VALUE_BITS'(in_data.value);
      kc_r  <= (k_ext > cnt_ext) ? count_r : CNT_W'(in_data.k);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    lat_nxt       = lat_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    ins_en        = 1'b0;
    era_en        = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if ((op_r == OP_SMALL) || (op_r == OP_LARGE)) begin
          state_nxt = S_SUM;
          lat_nxt   = LAT_W'(TREE_LAT - 1);
        end else if (out_free) begin
          out_data_nxt.sum    = '0;
          out_data_nxt.status = ST_OK;
          unique case (op_r)
            OP_INSERT: begin
              if (full) begin
                out_data_nxt.status = ST_FULL;
              end else begin
                ins_en    = 1'b1;
                count_nxt = count_r + 1'b1;
              end
            end
            OP_ERASE: begin
              if (found) begin
                era_en    = 1'b1;
                count_nxt = count_r - 1'b1;
              end else begin
                out_data_nxt.status = ST_NOT_FOUND;
              end
            end
            OP_CLEAR: begin
              count_nxt = '0;
            end
            default: begin
            end
          endcase
          out_data_nxt.count = OCNT_W'(count_nxt);
          out_valid_nxt      = 1'b1;
          state_nxt          = S_IDLE;
        end
      end
      S_SUM: begin
        if (lat_r != '0) begin
          lat_nxt = lat_r - 1'b1;
        end else if (out_free) begin
          out_data_nxt.sum    = SUM_W'(tree_sum);
          out_data_nxt.count  = OCNT_W'(count_r);
          out_data_nxt.status = ST_OK;
          out_valid_nxt       = 1'b1;
          state_nxt           = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      lat_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      lat_r       <= lat_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  // Broadcast to the cells: flags are sampled in the compare step, the shift
  // happens once in the apply step when the result can be written.
  always_comb begin
    ctl.cmp       = (state_r == S_CMP);
    ctl.ins_en    = ins_en;
    ctl.era_en    = era_en;
    ctl.sum_small = (op_r == OP_SMALL);
    ctl.sum_large = (op_r == OP_LARGE);
    ctl.val       = val_r;
    ctl.n         = count_r;
    ctl.kc        = kc_r;
  end

  // The row of cells; each cell sees only its two neighbors.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    val_t lv;
    logic lle;
    val_t rv;
    if (i == 0) begin : g_first
      assign lv  = val_r;
      assign lle = 1'b1;
    end else begin : g_mid
      assign lv  = cell_val[i-1];
      assign lle = cell_le[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign rv = cell_val[i];
    end else begin : g_inner
      assign rv = cell_val[i+1];
    end
    kss_cell u_cell (
      .clk         (clk),
      .idx         (IDX_W'(i)),
      .ctl         (ctl),
      .left_value  (lv),
      .left_le     (lle),
      .right_value (rv),
      .value       (cell_val[i]),
      .le          (cell_le[i]),
      .eq          (cell_eq[i]),
      .leaf        (cell_leaf[i])
    );
  end

  kss_sum_tree u_tree (
    .clk  (clk),
    .leaf (cell_leaf),
    .sum  (tree_sum)
  );

  // The count can never pass the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  // An accepted insert into a store with room grows the count by one.
  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC && op_r == OP_INSERT && !full && out_free)
    |=> count_r == $past(count_r) + 1'b1)
    else $error("insert did not grow the count");

  // An erase of an absent value leaves the count alone.
  a_erase_miss: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC && op_r == OP_ERASE && !found && out_free)
    |=> $stable(count_r))
    else $error("missed erase changed the count");

  // A result appears only from the apply or the sum step.
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_EXEC || $past(state_r) == S_SUM))
    else $error("result written outside the final step");

  // Held entries stay in ascending order between items.
  for (genvar i = 0; i < CAPACITY - 1; i++) begin : g_order
    a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
      (state_r == S_IDLE && CNT_W'(i + 1) < count_r) |-> cell_val[i] <= cell_val[i+1])
      else $error("store out of order");
  end

endmodule

`default_nettype wire
